// ===== sv/bmhq_pkg.sv =====
`default_nettype none

package bmhq_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int KEY_WIDTH_DEF  = 16;
   localparam int DATA_WIDTH_DEF = 16;

   localparam int CAP_W     = 5;
   localparam int CNT_OUT_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic FUNC_INSERT  = 1'b0;
   localparam logic FUNC_EXTRACT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_LAST,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DONE
   } hq_state_type;

   typedef enum logic [1:0] {
      RD_LAST,
      RD_PARENT,
      RD_CHILD
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_MV,
      WR_A,
      WR_B
   } wr_sel_type;

   typedef enum logic [1:0] {
      POS_PARENT,
      POS_LEFT,
      POS_RIGHT
   } pos_sel_type;

   typedef struct packed {
      logic        start;
      logic        load_ins;
      logic        load_ext;
      logic        ld_mv_rd;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        pos_ld;
      pos_sel_type pos_sel;
      logic        load_rsp;
   } hq_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic leaf;
      logic one_child;
      logic mv_lt_a;
      logic mv_gt_a;
      logic mv_gt_b;
      logic a_lt_b;
      logic rsp_free;
   } hq_status_type;

endpackage

`default_nettype wire

// ===== sv/bmhq_ctrl.sv =====
`default_nettype none

module bmhq_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire                     req_func,
   input  bmhq_pkg::hq_status_type status,
   output bmhq_pkg::hq_cmd_type    cmd
);

   bmhq_pkg::hq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmhq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmhq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_func == bmhq_pkg::FUNC_INSERT && !status.full) begin
                  state_in = bmhq_pkg::ST_UP_RD;
               end else if (req_func == bmhq_pkg::FUNC_EXTRACT && !status.empty) begin
                  state_in = bmhq_pkg::ST_DN_LAST;
               end else begin
                  state_in = bmhq_pkg::ST_DONE;
               end
            end
         end
         bmhq_pkg::ST_UP_RD: begin
            state_in = status.pos_zero ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_UP_CMP;
         end
         bmhq_pkg::ST_UP_CMP: begin
            state_in = status.mv_lt_a ? bmhq_pkg::ST_UP_RD : bmhq_pkg::ST_DONE;
         end
         bmhq_pkg::ST_DN_LAST: begin
            state_in = status.empty ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_DN_RD;
         end
         bmhq_pkg::ST_DN_RD: begin
            state_in = status.leaf ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_DN_CMP;
         end
         bmhq_pkg::ST_DN_CMP: begin
            if (status.one_child) begin
               state_in = status.mv_gt_a ? bmhq_pkg::ST_DN_RD : bmhq_pkg::ST_DONE;
            end else if (!status.mv_gt_a && !status.mv_gt_b) begin
               state_in = bmhq_pkg::ST_DONE;
            end else begin
               state_in = bmhq_pkg::ST_DN_RD;
            end
         end
         bmhq_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               state_in = bmhq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bmhq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = bmhq_pkg::RD_LAST;
      cmd.wr_sel   = bmhq_pkg::WR_MV;
      cmd.pos_sel  = bmhq_pkg::POS_PARENT;
      req_tready   = 1'b0;
      case (state_ff)
         bmhq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               if (req_func == bmhq_pkg::FUNC_INSERT && !status.full) begin
                  cmd.load_ins = 1'b1;
               end else if (req_func == bmhq_pkg::FUNC_EXTRACT && !status.empty) begin
                  cmd.load_ext = 1'b1;
                  cmd.rd_en    = 1'b1;
                  cmd.rd_sel   = bmhq_pkg::RD_LAST;
               end
            end
         end
         bmhq_pkg::ST_UP_RD: begin
            if (status.pos_zero) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = bmhq_pkg::WR_MV;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bmhq_pkg::RD_PARENT;
            end
         end
         bmhq_pkg::ST_UP_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.mv_lt_a) begin
               cmd.wr_sel  = bmhq_pkg::WR_A;
               cmd.pos_ld  = 1'b1;
               cmd.pos_sel = bmhq_pkg::POS_PARENT;
            end else begin
               cmd.wr_sel = bmhq_pkg::WR_MV;
            end
         end
         bmhq_pkg::ST_DN_LAST: begin
            cmd.ld_mv_rd = !status.empty;
         end
         bmhq_pkg::ST_DN_RD: begin
            if (status.leaf) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = bmhq_pkg::WR_MV;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bmhq_pkg::RD_CHILD;
            end
         end
         bmhq_pkg::ST_DN_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.one_child) begin
               if (status.mv_gt_a) begin
                  cmd.wr_sel  = bmhq_pkg::WR_A;
                  cmd.pos_ld  = 1'b1;
                  cmd.pos_sel = bmhq_pkg::POS_LEFT;
               end else begin
                  cmd.wr_sel = bmhq_pkg::WR_MV;
               end
            end else if (!status.mv_gt_a && !status.mv_gt_b) begin
               cmd.wr_sel = bmhq_pkg::WR_MV;
            end else if (status.a_lt_b) begin
               cmd.wr_sel  = bmhq_pkg::WR_A;
               cmd.pos_ld  = 1'b1;
               cmd.pos_sel = bmhq_pkg::POS_LEFT;
            end else begin
               cmd.wr_sel  = bmhq_pkg::WR_B;
               cmd.pos_ld  = 1'b1;
               cmd.pos_sel = bmhq_pkg::POS_RIGHT;
            end
         end
         bmhq_pkg::ST_DONE: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            cmd.load_rsp = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/bmhq_dpath.sv =====
`default_nettype none

module bmhq_dpath #(
   parameter int DEPTH      = bmhq_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH  = bmhq_pkg::KEY_WIDTH_DEF,
   parameter int DATA_WIDTH = bmhq_pkg::DATA_WIDTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  bmhq_pkg::hq_cmd_type             cmd,
   output bmhq_pkg::hq_status_type          status,
   input  wire  [KEY_WIDTH-1:0]             in_key,
   input  wire  [DATA_WIDTH-1:0]            in_payload,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [bmhq_pkg::CAP_W-1:0]       csr_data,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic                             rsp_done_ok,
   output logic [KEY_WIDTH-1:0]             rsp_out_key,
   output logic [DATA_WIDTH-1:0]            rsp_out_payload,
   output logic [KEY_WIDTH-1:0]             rsp_top_key,
   output logic [DATA_WIDTH-1:0]            rsp_top_payload,
   output logic [bmhq_pkg::CNT_OUT_W-1:0]   rsp_entry_count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CH_W  = IDX_W + 2;
   localparam int CMP_W = (CNT_W > bmhq_pkg::CAP_W) ? CNT_W : bmhq_pkg::CAP_W;

   logic [KEY_WIDTH-1:0]  slot_key_mem [DEPTH];
   logic [DATA_WIDTH-1:0] slot_pay_mem [DEPTH];

   logic [bmhq_pkg::CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           pos_ff, pos_in;
   logic [KEY_WIDTH-1:0]       mv_key_ff, mv_key_in;
   logic [DATA_WIDTH-1:0]      mv_pay_ff, mv_pay_in;
   logic [KEY_WIDTH-1:0]       top_key_ff;
   logic [DATA_WIDTH-1:0]      top_pay_ff;
   logic [KEY_WIDTH-1:0]       rd_a_key_ff, rd_b_key_ff;
   logic [DATA_WIDTH-1:0]      rd_a_pay_ff, rd_b_pay_ff;
   logic                       ok_ff;
   logic [KEY_WIDTH-1:0]       res_key_ff;
   logic [DATA_WIDTH-1:0]      res_pay_ff;
   logic                       rsp_valid_ff;

   logic [CH_W-1:0]            count_ch, left_ch, right_ch;
   logic [CNT_W-1:0]           last_cnt;
   logic [IDX_W-1:0]           last_idx, parent_idx, left_idx, right_idx, rd_addr_a;
   logic [KEY_WIDTH-1:0]       wr_key;
   logic [DATA_WIDTH-1:0]      wr_pay;
   logic [CMP_W-1:0]           count_cmp, cap_cmp;

   assign count_ch   = CH_W'(count_ff);
   assign left_ch    = CH_W'({pos_ff, 1'b0}) + CH_W'(1);
   assign right_ch   = left_ch + CH_W'(1);
   assign left_idx   = left_ch[IDX_W-1:0];
   assign right_idx  = right_ch[IDX_W-1:0];
   assign last_cnt   = count_ff - CNT_W'(1);
   assign last_idx   = last_cnt[IDX_W-1:0];
   assign parent_idx = (pos_ff - IDX_W'(1)) >> 1;
   assign count_cmp  = CMP_W'(count_ff);
   assign cap_cmp    = CMP_W'(cap_ff);

   always_comb begin
      case (cmd.rd_sel)
         bmhq_pkg::RD_LAST:   rd_addr_a = last_idx;
         bmhq_pkg::RD_PARENT: rd_addr_a = parent_idx;
         bmhq_pkg::RD_CHILD:  rd_addr_a = left_idx;
         default:             rd_addr_a = last_idx;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         bmhq_pkg::WR_A: begin
            wr_key = rd_a_key_ff;
            wr_pay = rd_a_pay_ff;
         end
         bmhq_pkg::WR_B: begin
            wr_key = rd_b_key_ff;
            wr_pay = rd_b_pay_ff;
         end
         default: begin
            wr_key = mv_key_ff;
            wr_pay = mv_pay_ff;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.load_ext) begin
         count_in = last_cnt;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.load_ins) begin
         pos_in = count_ff[IDX_W-1:0];
      end else if (cmd.load_ext) begin
         pos_in = '0;
      end else if (cmd.pos_ld) begin
         case (cmd.pos_sel)
            bmhq_pkg::POS_PARENT: pos_in = parent_idx;
            bmhq_pkg::POS_LEFT:   pos_in = left_idx;
            bmhq_pkg::POS_RIGHT:  pos_in = right_idx;
            default:              pos_in = pos_ff;
         endcase
      end
   end

   always_comb begin
      mv_key_in = mv_key_ff;
      mv_pay_in = mv_pay_ff;
      if (cmd.start) begin
         mv_key_in = in_key;
         mv_pay_in = in_payload;
      end else if (cmd.ld_mv_rd) begin
         mv_key_in = rd_a_key_ff;
         mv_pay_in = rd_a_pay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= bmhq_pkg::CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
         count_ff <= count_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      mv_key_ff <= mv_key_in;
      mv_pay_ff <= mv_pay_in;
      if (cmd.start) begin
         ok_ff      <= cmd.load_ins | cmd.load_ext;
         res_key_ff <= cmd.load_ext ? top_key_ff : '0;
         res_pay_ff <= cmd.load_ext ? top_pay_ff : '0;
      end
      if (cmd.wr_en && pos_ff == '0) begin
         top_key_ff <= wr_key;
         top_pay_ff <= wr_pay;
      end
      if (cmd.load_rsp) begin
         rsp_done_ok     <= ok_ff;
         rsp_out_key     <= res_key_ff;
         rsp_out_payload <= res_pay_ff;
         rsp_top_key     <= (count_ff == '0) ? '0 : top_key_ff;
         rsp_top_payload <= (count_ff == '0) ? '0 : top_pay_ff;
         rsp_entry_count <= count_cmp[bmhq_pkg::CNT_OUT_W-1:0];
      end
   end

   // heap storage: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_key_mem[pos_ff] <= wr_key;
         slot_pay_mem[pos_ff] <= wr_pay;
      end
      if (cmd.rd_en) begin
         rd_a_key_ff <= slot_key_mem[rd_addr_a];
         rd_a_pay_ff <= slot_pay_mem[rd_addr_a];
      end
      if (cmd.rd_en && cmd.rd_sel == bmhq_pkg::RD_CHILD) begin
         rd_b_key_ff <= slot_key_mem[right_idx];
         rd_b_pay_ff <= slot_pay_mem[right_idx];
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;

   assign status.full      = (count_cmp >= cap_cmp) || (count_ff == CNT_W'(DEPTH));
   assign status.empty     = (count_ff == '0);
   assign status.pos_zero  = (pos_ff == '0);
   assign status.leaf      = (left_ch >= count_ch);
   assign status.one_child = (right_ch >= count_ch);
   assign status.mv_lt_a   = (mv_key_ff < rd_a_key_ff);
   assign status.mv_gt_a   = (mv_key_ff > rd_a_key_ff);
   assign status.mv_gt_b   = (mv_key_ff > rd_b_key_ff);
   assign status.a_lt_b    = (rd_a_key_ff < rd_b_key_ff);
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && !cmd.load_ins && !cmd.load_ext) |=> $stable(count_ff))
      else $error("refused transfer changed entry count");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (CH_W'(pos_ff) < count_ch))
      else $error("heap write outside held entries");

   a_failed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_done_ok) |-> (rsp_out_key == '0 && rsp_out_payload == '0))
      else $error("failed transfer carries nonzero entry");

endmodule

`default_nettype wire

// ===== sv/binary_min_heap_queue_unit.sv =====
// Binary min-heap priority queue of key/payload entries, smallest unsigned key served
// first. req_tuser selects insert or extract; each request transfer yields exactly one
// response transfer carrying the extracted entry, the new root and the entry count.
// Each heap level takes one registered memory read, then a compare and move. An insert
// sifts up until a compare stops it or it reaches the root; an extract moves the last
// entry to the root and sifts down until a compare stops it or it reaches a leaf. A
// refused insert or an empty extract goes straight to its response. A finished response
// waits in its output register while the next request is taken; a second response
// stalls the queue only while that register is still full. The capacity register must
// be written by the user through the csr channel only while the queue is idle; the
// block itself does not enforce it. Heap memory needs no clearing after reset.
`default_nettype none

module binary_min_heap_queue_unit #(
   parameter int DEPTH      = bmhq_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH  = bmhq_pkg::KEY_WIDTH_DEF,
   parameter int DATA_WIDTH = bmhq_pkg::DATA_WIDTH_DEF,
   localparam int REQ_W     = ((KEY_WIDTH + DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_F_W   = 2 * KEY_WIDTH + 2 * DATA_WIDTH + bmhq_pkg::CNT_OUT_W,
   localparam int RSP_W     = ((RSP_F_W + 7) / 8) * 8
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [REQ_W-1:0]             req_tdata,  // in_key, in_payload
   input  wire  [0:0]                   req_tuser,  // func
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [RSP_W-1:0]             rsp_tdata,  // out_key, out_payload, top_key,
                                                    // top_payload, entry_count
   output logic [0:0]                   rsp_tuser,  // done_ok
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [bmhq_pkg::CAP_W-1:0]   csr_data    // capacity
);

   bmhq_pkg::hq_cmd_type    cmd;
   bmhq_pkg::hq_status_type status;

   logic                               done_ok;
   logic [KEY_WIDTH-1:0]               out_key, top_key;
   logic [DATA_WIDTH-1:0]              out_payload, top_payload;
   logic [bmhq_pkg::CNT_OUT_W-1:0]     entry_count;

   bmhq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser[0]),
      .status     (status),
      .cmd        (cmd)
   );

   bmhq_dpath #(
      .DEPTH      (DEPTH),
      .KEY_WIDTH  (KEY_WIDTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_key          (req_tdata[KEY_WIDTH-1:0]),
      .in_payload      (req_tdata[KEY_WIDTH+DATA_WIDTH-1:KEY_WIDTH]),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_done_ok     (done_ok),
      .rsp_out_key     (out_key),
      .rsp_out_payload (out_payload),
      .rsp_top_key     (top_key),
      .rsp_top_payload (top_payload),
      .rsp_entry_count (entry_count)
   );

   assign rsp_tdata = RSP_W'({entry_count, top_payload, top_key, out_payload, out_key});
   assign rsp_tuser = done_ok;

endmodule

`default_nettype wire

// ===== tb/sv/binary_min_heap_queue_unit_test.sv =====
`default_nettype none

module binary_min_heap_queue_unit_test;

   localparam int HEAP_DEPTH  = bmhq_pkg::DEPTH_DEF;
   localparam int REQ_BITS    = 32;
   localparam int RSP_BITS    = 72;
   localparam int IDLE_LIMIT  = 2000;
   localparam int LONG_HOLD   = 400;
   localparam int PHASE_ITEMS = 100;
   localparam int PHASES      = 14;

   typedef struct packed {
      logic                                ok;
      logic [bmhq_pkg::KEY_WIDTH_DEF-1:0]  out_key;
      logic [bmhq_pkg::DATA_WIDTH_DEF-1:0] out_payload;
      logic [bmhq_pkg::KEY_WIDTH_DEF-1:0]  top_key;
      logic [bmhq_pkg::DATA_WIDTH_DEF-1:0] top_payload;
      logic [bmhq_pkg::CNT_OUT_W-1:0]      count;
   } heap_result_type;

   class heap_shadow;
      logic [bmhq_pkg::KEY_WIDTH_DEF-1:0]  keys [HEAP_DEPTH];
      logic [bmhq_pkg::DATA_WIDTH_DEF-1:0] pays [HEAP_DEPTH];
      int unsigned                         held;
      logic [bmhq_pkg::CAP_W-1:0]          capacity;
      heap_result_type                     pending [$];
      int unsigned                         errors;

      function new();
         held     = 0;
         capacity = bmhq_pkg::CAP_RESET;
         errors   = 0;
      endfunction

      function void set_capacity(logic [bmhq_pkg::CAP_W-1:0] value);
         capacity = value;
      endfunction

      function void swap_slots(int a, int b);
         logic [bmhq_pkg::KEY_WIDTH_DEF-1:0]  k;
         logic [bmhq_pkg::DATA_WIDTH_DEF-1:0] p;
         k = keys[a];
         p = pays[a];
         keys[a] = keys[b];
         pays[a] = pays[b];
         keys[b] = k;
         pays[b] = p;
      endfunction

      function void sift_up();
         int n;
         int par;
         n = held - 1;
         while (n > 0) begin
            par = (n - 1) / 2;
            if (keys[n] < keys[par]) begin
               swap_slots(n, par);
               n = par;
            end else begin
               break;
            end
         end
      endfunction

      function void sift_down();
         int n;
         int l;
         int r;
         n = 0;
         while (2 * n + 1 < held) begin
            l = 2 * n + 1;
            r = l + 1;
            if (r >= held) begin
               // single child: one compare, then stop
               if (keys[n] > keys[l]) swap_slots(n, l);
               break;
            end
            if (!(keys[n] > keys[l]) && !(keys[n] > keys[r])) break;
            if (keys[l] < keys[r]) begin
               swap_slots(n, l);
               n = l;
            end else begin
               swap_slots(n, r);
               n = r;
            end
         end
      endfunction

      function void apply_request(logic func, logic [bmhq_pkg::KEY_WIDTH_DEF-1:0] key,
                                  logic [bmhq_pkg::DATA_WIDTH_DEF-1:0] pay);
         int unsigned     limit;
         heap_result_type res;
         limit = (capacity > HEAP_DEPTH) ? HEAP_DEPTH : capacity;
         res   = '0;
         if (func == bmhq_pkg::FUNC_INSERT) begin
            if (held < limit) begin
               keys[held] = key;
               pays[held] = pay;
               held++;
               sift_up();
               res.ok = 1'b1;
            end
         end else if (held > 0) begin
            res.out_key     = keys[0];
            res.out_payload = pays[0];
            held--;
            keys[0] = keys[held];
            pays[0] = pays[held];
            sift_down();
            res.ok = 1'b1;
         end
         if (held > 0) begin
            res.top_key     = keys[0];
            res.top_payload = pays[0];
         end
         res.count = held[bmhq_pkg::CNT_OUT_W-1:0];
         pending.push_back(res);
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void compare_response(logic [RSP_BITS-1:0] data, logic flag);
         heap_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response transfer: expected none, actual %0h/%0h",
                     $time, flag, data);
            errors++;
            return;
         end
         want = pending.pop_front();
         check_field("done_ok", want.ok, flag);
         check_field("out_key", want.out_key, data[15:0]);
         check_field("out_payload", want.out_payload, data[31:16]);
         check_field("top_key", want.top_key, data[47:32]);
         check_field("top_payload", want.top_payload, data[63:48]);
         check_field("entry_count", want.count, data[68:64]);
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_BITS-1:0]         req_tdata = '0;
   logic [0:0]                  req_tuser = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]         rsp_tdata;
   logic [0:0]                  rsp_tuser;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [bmhq_pkg::CAP_W-1:0]  csr_data = '0;

   heap_shadow  heap = new();
   int          sender_gap_mode = 1;
   int          receiver_gap_mode = 1;
   int unsigned responses_seen = 0;
   int unsigned idle_cycles = 0;

   binary_min_heap_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int draw_gap(int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 14);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
      endcase
   endfunction

   function automatic logic [bmhq_pkg::KEY_WIDTH_DEF-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 7));
         1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic push_request(input logic func, input logic [15:0] key,
                               input logic [15:0] pay);
      int gap;
      gap = draw_gap(sender_gap_mode);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {pay, key};
      do @(posedge clock); while (!req_tready);
      heap.apply_request(func, key, pay);
   endtask

   task automatic drain_heap_traffic();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (heap.pending.size() != 0);
   endtask

   task automatic write_capacity(input logic [bmhq_pkg::CAP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      heap.set_capacity(value);
   endtask

   // response side: random stalls, plus long hold-offs so the queue backs up
   initial begin
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (responses_seen == 300 || responses_seen == 900) gap = LONG_HOLD;
         else gap = draw_gap(receiver_gap_mode);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         heap.compare_response(rsp_tdata, rsp_tuser[0]);
         responses_seen++;
         if (responses_seen % 128 == 0) receiver_gap_mode = $urandom_range(0, 2);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [bmhq_pkg::CAP_W-1:0] cap_plan [7];
      logic [bmhq_pkg::CAP_W-1:0] cap;
      int                         insert_pct;
      logic                       func;
      cap_plan = '{5'd31, 5'd3, 5'd16, 5'd1, 5'd0, 5'd17, 5'd8};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty extract, extremes, sift up to root, equal keys, drain to empty
      push_request(bmhq_pkg::FUNC_EXTRACT, 16'h0000, 16'h0000);
      push_request(bmhq_pkg::FUNC_INSERT, 16'hFFFF, 16'h0000);
      push_request(bmhq_pkg::FUNC_INSERT, 16'h0000, 16'hFFFF);
      push_request(bmhq_pkg::FUNC_INSERT, 16'h8000, 16'h1111);
      push_request(bmhq_pkg::FUNC_INSERT, 16'h8000, 16'h2222);
      push_request(bmhq_pkg::FUNC_INSERT, 16'h8000, 16'h3333);
      push_request(bmhq_pkg::FUNC_INSERT, 16'h0001, 16'hAAAA);
      repeat (7) push_request(bmhq_pkg::FUNC_EXTRACT, 16'hFFFF, 16'hFFFF);
      drain_heap_traffic();

      // full heap refuses insert
      write_capacity(5'd2);
      push_request(bmhq_pkg::FUNC_INSERT, 16'h0005, 16'h0005);
      push_request(bmhq_pkg::FUNC_INSERT, 16'h0003, 16'h0003);
      push_request(bmhq_pkg::FUNC_INSERT, 16'h0009, 16'h0009);
      repeat (3) push_request(bmhq_pkg::FUNC_EXTRACT, 16'h0000, 16'h0000);
      drain_heap_traffic();

      // zero capacity refuses everything
      write_capacity(5'd0);
      push_request(bmhq_pkg::FUNC_INSERT, 16'h0001, 16'h0001);
      push_request(bmhq_pkg::FUNC_EXTRACT, 16'h0000, 16'h0000);
      drain_heap_traffic();

      for (int phase = 0; phase < PHASES; phase++) begin
         cap = (phase < 7) ? cap_plan[phase] : 5'($urandom_range(0, 31));
         write_capacity(cap);
         sender_gap_mode = phase % 3;
         case ($urandom_range(0, 2))
            0: insert_pct = 75;
            1: insert_pct = 50;
            default: insert_pct = 25;
         endcase
         if (phase == 0) insert_pct = 80;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            func = ($urandom_range(0, 99) < insert_pct) ? bmhq_pkg::FUNC_INSERT
                                                        : bmhq_pkg::FUNC_EXTRACT;
            push_request(func, pick_key(), 16'($urandom()));
         end
         drain_heap_traffic();
      end

      repeat (20) @(posedge clock);
      if (heap.errors == 0 && heap.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
sv/bmhq_pkg.sv
sv/bmhq_ctrl.sv
sv/bmhq_dpath.sv
sv/binary_min_heap_queue_unit.sv
tb/sv/binary_min_heap_queue_unit_test.sv
